// ----- design/ltlb_pkg.sv -----
// ----------------------------------------------------------------------------
// ltlb_pkg
// Shared widths, register indexes, codes and types of the LRU translation
// buffer.
// ----------------------------------------------------------------------------
package ltlb_pkg;

   localparam int LVL_W           = 16;
   localparam int FRAME_W         = 20;
   localparam int CAP_W           = 5;
   localparam int LVLS_W          = 3;
   localparam int CSR_W           = 5;
   localparam int CSR_IDX_W       = 1;
   localparam int NUM_LEVEL_PORTS = 4;
   localparam int DEF_MAX_ENTRIES = 16;
   localparam int DEF_MAX_LEVELS  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVELS   = 1'b1;

   localparam logic [CAP_W-1:0]  CAPACITY_RESET = 5'd16;
   localparam logic [LVLS_W-1:0] LEVELS_RESET   = 3'd1;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   // commands to the recency tracker
   typedef enum logic [1:0] {
      ROP_IDLE,
      ROP_TOUCH,
      ROP_EVICT,
      ROP_FILL
   } ltlb_rop_type;

   typedef struct packed {
      logic slot_valid;
      logic full;
   } ltlb_rstat_type;

   typedef logic [NUM_LEVEL_PORTS-1:0][LVL_W-1:0] ltlb_levels_type;

endpackage

// ----- design/ltlb_entry_ram.sv -----
// ----------------------------------------------------------------------------
// ltlb_entry_ram
// Single-port-write, single-port-read entry store; registered read data.
// ----------------------------------------------------------------------------
module ltlb_entry_ram #(
   parameter int ADDR_W = 4,
   parameter int DEPTH  = 16,
   parameter int DATA_W = 84
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/ltlb_recency.sv -----
// ----------------------------------------------------------------------------
// ltlb_recency
// Valid bits, recency ranks and entry count. Rank 0 is the most recent.
// Applies touch, eviction and fill updates to all entries together.
// ----------------------------------------------------------------------------
module ltlb_recency import ltlb_pkg::*; #(
   parameter  int MAX_ENTRIES = DEF_MAX_ENTRIES,
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int RANK_W      = IDX_W,
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  ltlb_rop_type   op,
   input  logic [IDX_W-1:0] idx,
   input  logic [CNT_W-1:0] cap,
   output ltlb_rstat_type stat,
   output logic [RANK_W-1:0] slot_rank
);

   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [RANK_W-1:0]      rank_ff [MAX_ENTRIES];
   logic [RANK_W-1:0]      rank_in [MAX_ENTRIES];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       cap_m1;
   logic [RANK_W-1:0]      touch_rank;
   logic                   full;

   assign full            = (count_ff >= cap);
   assign stat.full       = full;
   assign stat.slot_valid = valid_ff[idx];
   assign slot_rank       = rank_ff[idx];

   always_comb begin
      cap_m1     = cap - 1'b1;
      touch_rank = rank_ff[idx];
      valid_in   = valid_ff;
      rank_in    = rank_ff;
      count_in   = count_ff;
      case (op)
         ROP_TOUCH: begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (valid_ff[i] && (rank_ff[i] < touch_rank)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            rank_in[idx] = '0;
         end
         ROP_EVICT: begin
            // ranks are distinct 0..count-1: dropping every rank at or above
            // cap-1 equals evicting the oldest until one slot is free
            if (full) begin
               for (int i = 0; i < MAX_ENTRIES; i++) begin
                  if (valid_ff[i] && (CNT_W'(rank_ff[i]) >= cap_m1)) begin
                     valid_in[i] = 1'b0;
                     rank_in[i]  = '0;
                  end
               end
               count_in = cap_m1;
            end
         end
         ROP_FILL: begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            valid_in[idx] = 1'b1;
            rank_in[idx]  = '0;
            count_in      = count_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         rank_ff  <= rank_in;
      end
   end

endmodule

// ----- design/ltlb_seq.sv -----
// ----------------------------------------------------------------------------
// ltlb_seq
// Item sequencer: key scan over the entry RAM for lookups, evict and
// free-slot sweep for inserts, result register.
// ----------------------------------------------------------------------------
module ltlb_seq import ltlb_pkg::*; #(
   parameter  int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter  int KEY_LEVELS  = NUM_LEVEL_PORTS,
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int RANK_W      = IDX_W,
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1),
   localparam int KEY_W       = LVL_W * KEY_LEVELS,
   localparam int DATA_W      = FRAME_W + KEY_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                kind,
   input  ltlb_levels_type     levels,
   input  logic [FRAME_W-1:0]  frame_number,
   input  logic [CNT_W-1:0]    cap,
   input  logic [LVLS_W-1:0]   levels_eff,
   output logic                rsp_valid,
   output logic                rsp_hit,
   output logic [FRAME_W-1:0]  rsp_hit_frame,
   output logic                rsp_evicted,
   output logic                ram_wr_en,
   output logic [IDX_W-1:0]    ram_wr_addr,
   output logic [DATA_W-1:0]   ram_wr_data,
   output logic                ram_rd_en,
   output logic [IDX_W-1:0]    ram_rd_addr,
   input  logic [DATA_W-1:0]   ram_rd_data,
   output ltlb_rop_type        rop,
   output logic [IDX_W-1:0]    ridx,
   input  ltlb_rstat_type      rstat,
   input  logic [RANK_W-1:0]   slot_rank
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_DECIDE,
      S_EVICT,
      S_FILL
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       addr_ff, addr_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic                   pend_ff, pend_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [RANK_W-1:0]      best_rank_ff, best_rank_in;
   logic [FRAME_W-1:0]     best_frame_ff, best_frame_in;
   logic                   evicted_ff, evicted_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [KEY_LEVELS-1:0]  mask_ff, mask_in;
   logic [FRAME_W-1:0]     frame_ff, frame_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [FRAME_W-1:0]     rsp_frame_ff, rsp_frame_in;
   logic                   rsp_evicted_ff, rsp_evicted_in;
   logic                   match;
   logic                   take;

   // key compare on the entry arriving from the RAM
   always_comb begin
      match = 1'b1;
      for (int l = 0; l < KEY_LEVELS; l++) begin
         if (mask_ff[l] &&
             (ram_rd_data[l*LVL_W +: LVL_W] != key_ff[l*LVL_W +: LVL_W])) begin
            match = 1'b0;
         end
      end
   end

   // oldest matching entry wins
   assign take = pend_ff && rstat.slot_valid && match &&
                 (!found_ff || (slot_rank > best_rank_ff));

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      chk_idx_in     = chk_idx_ff;
      pend_in        = 1'b0;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_rank_in   = best_rank_ff;
      best_frame_in  = best_frame_ff;
      evicted_in     = evicted_ff;
      key_in         = key_ff;
      mask_in        = mask_ff;
      frame_in       = frame_ff;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = 1'b0;
      rsp_frame_in   = '0;
      rsp_evicted_in = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = addr_ff;
      ram_wr_data    = {frame_ff, key_ff};
      ram_rd_en      = 1'b0;
      ram_rd_addr    = addr_ff;
      rop            = ROP_IDLE;
      ridx           = pend_ff ? chk_idx_ff : addr_ff;

      if (take) begin
         found_in      = 1'b1;
         best_idx_in   = chk_idx_ff;
         best_rank_in  = slot_rank;
         best_frame_in = ram_rd_data[DATA_W-1 -: FRAME_W];
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               for (int l = 0; l < KEY_LEVELS; l++) begin
                  key_in[l*LVL_W +: LVL_W] = levels[l];
                  mask_in[l]               = (LVLS_W'(l) < levels_eff);
               end
               frame_in   = frame_number;
               addr_in    = '0;
               found_in   = 1'b0;
               evicted_in = 1'b0;
               if (kind == KIND_LOOKUP) begin
                  state_in = S_SCAN;
               end else if (cap == '0) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = S_EVICT;
               end
            end
         end
         S_SCAN: begin
            ram_rd_en  = 1'b1;
            pend_in    = 1'b1;
            chk_idx_in = addr_ff;
            if (addr_ff == LAST_IDX) begin
               state_in = S_LAST;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_LAST: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            rsp_valid_in = 1'b1;
            rsp_hit_in   = found_ff;
            rsp_frame_in = found_ff ? best_frame_ff : '0;
            if (found_ff) begin
               rop  = ROP_TOUCH;
               ridx = best_idx_ff;
            end
            state_in = S_IDLE;
         end
         S_EVICT: begin
            rop        = ROP_EVICT;
            evicted_in = rstat.full;
            state_in   = S_FILL;
         end
         S_FILL: begin
            if (!rstat.slot_valid) begin
               rop            = ROP_FILL;
               ram_wr_en      = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_evicted_in = evicted_ff;
               state_in       = S_IDLE;
            end else if (addr_ff == LAST_IDX) begin
               rsp_valid_in   = 1'b1;
               rsp_evicted_in = evicted_ff;
               state_in       = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff        <= addr_in;
      chk_idx_ff     <= chk_idx_in;
      found_ff       <= found_in;
      best_idx_ff    <= best_idx_in;
      best_rank_ff   <= best_rank_in;
      best_frame_ff  <= best_frame_in;
      evicted_ff     <= evicted_in;
      key_ff         <= key_in;
      mask_ff        <= mask_in;
      frame_ff       <= frame_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_hit_frame = rsp_frame_ff;
   assign rsp_evicted   = rsp_evicted_ff;

endmodule

// ----- design/lru_tlb_lookup_insert.sv -----
// ----------------------------------------------------------------------------
// lru_tlb_lookup_insert
// Fully associative translation buffer with least-recently-used replacement.
//
//   channel  | handshake           | beat contents
//   ---------+---------------------+---------------------------------------
//   request  | start && !busy      | req_kind, req_level_index_0..3,
//            |                     | req_frame_number
//   response | rsp_valid (1 cycle) | rsp_hit, rsp_hit_frame, rsp_evicted
//   csr      | csr_wr_en           | csr_index, csr_wdata
//
// Lookup: one-entry-per-cycle key scan through the entry RAM read port,
// then a last state and a decide state, with busy high throughout.
// Insert: evict step, then free-slot sweep; with capacity zero, neither
// step runs and busy stays low. One response beat per item, in the first
// cycle with busy low after the accept. Synchronous reset clears valid bits,
// count and control; no clearing pass. The response side cannot stall.
// ----------------------------------------------------------------------------
module lru_tlb_lookup_insert import ltlb_pkg::*; #(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int MAX_LEVELS  = DEF_MAX_LEVELS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_kind,
   input  logic [LVL_W-1:0]     req_level_index_0,
   input  logic [LVL_W-1:0]     req_level_index_1,
   input  logic [LVL_W-1:0]     req_level_index_2,
   input  logic [LVL_W-1:0]     req_level_index_3,
   input  logic [FRAME_W-1:0]   req_frame_number,
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output logic [FRAME_W-1:0]   rsp_hit_frame,
   output logic                 rsp_evicted,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RANK_W     = IDX_W;
   localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int KEY_LEVELS = (MAX_LEVELS < NUM_LEVEL_PORTS) ? MAX_LEVELS
                                                               : NUM_LEVEL_PORTS;
   localparam int KEY_W      = LVL_W * KEY_LEVELS;
   localparam int DATA_W     = FRAME_W + KEY_W;
   localparam logic [CMP_W-1:0]  MAX_CMP  = CMP_W'(MAX_ENTRIES);
   localparam logic [LVLS_W-1:0] KEY_LVLS = LVLS_W'(KEY_LEVELS);

   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic [LVLS_W-1:0] levels_ff, levels_in;
   logic [CMP_W-1:0]  cap_wide;
   logic [CNT_W-1:0]  cap_eff;
   logic [LVLS_W-1:0] levels_eff;
   ltlb_levels_type   lvl_idx;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;
   ltlb_rop_type      rop;
   logic [IDX_W-1:0]  ridx;
   ltlb_rstat_type    rstat;
   logic [RANK_W-1:0] slot_rank;

   always_comb begin
      capacity_in = capacity_ff;
      levels_in   = levels_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CAPACITY: capacity_in = csr_wdata[CAP_W-1:0];
            CSR_LEVELS:   levels_in   = csr_wdata[LVLS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         levels_ff   <= LEVELS_RESET;
      end else begin
         capacity_ff <= capacity_in;
         levels_ff   <= levels_in;
      end
   end

   // capacity saturates at the entry count; levels clamp to 1..KEY_LEVELS
   always_comb begin
      cap_wide   = CMP_W'(capacity_ff);
      cap_eff    = (cap_wide > MAX_CMP) ? CNT_W'(MAX_ENTRIES) : CNT_W'(cap_wide);
      levels_eff = (levels_ff == '0) ? LVLS_W'(1) : levels_ff;
      if (levels_eff > KEY_LVLS) begin
         levels_eff = KEY_LVLS;
      end
   end

   assign lvl_idx[0] = req_level_index_0;
   assign lvl_idx[1] = req_level_index_1;
   assign lvl_idx[2] = req_level_index_2;
   assign lvl_idx[3] = req_level_index_3;

   ltlb_seq #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_LEVELS  (KEY_LEVELS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .kind          (req_kind),
      .levels        (lvl_idx),
      .frame_number  (req_frame_number),
      .cap           (cap_eff),
      .levels_eff    (levels_eff),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_hit_frame (rsp_hit_frame),
      .rsp_evicted   (rsp_evicted),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data),
      .rop           (rop),
      .ridx          (ridx),
      .rstat         (rstat),
      .slot_rank     (slot_rank)
   );

   ltlb_entry_ram #(
      .ADDR_W (IDX_W),
      .DEPTH  (MAX_ENTRIES),
      .DATA_W (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ltlb_recency #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_recency (
      .clock     (clock),
      .reset     (reset),
      .op        (rop),
      .idx       (ridx),
      .cap       (cap_eff),
      .stat      (rstat),
      .slot_rank (slot_rank)
   );

endmodule

// ----- design/ltlb_checker.sv -----
// ----------------------------------------------------------------------------
// ltlb_checker
// Port-level checks of the translation buffer, bound to the top level.
// ----------------------------------------------------------------------------
module ltlb_checker import ltlb_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_kind,
   input logic               rsp_valid,
   input logic               rsp_hit,
   input logic [FRAME_W-1:0] rsp_hit_frame,
   input logic               rsp_evicted
);

   logic last_kind_ff;

   // kind of the most recently accepted request beat
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         last_kind_ff <= req_kind;
      end
   end

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("busy or response right after reset");

   a_lookup_scans: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_kind == KIND_LOOKUP) |=> busy)
      else $error("lookup accepted without a scan");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response beat while still busy");

   a_hit_from_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> (last_kind_ff == KIND_LOOKUP) && !rsp_evicted)
      else $error("hit reported for an insert");

   a_evict_from_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> (last_kind_ff == KIND_INSERT) &&
                                   (rsp_hit_frame == '0))
      else $error("eviction reported for a lookup");

endmodule

bind lru_tlb_lookup_insert ltlb_checker u_ltlb_checker (.*);

// ----- bench/tb_lru_tlb_lookup_insert.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_tlb_lookup_insert
// Self-checking bench for the LRU translation buffer. A directed table walks
// empty lookups, extremes, duplicate keys, partial-level matches, capacity
// shrink, capacity zero and saturated register values; random phases then
// mix inserts and lookups, mostly on keys from a small key pool, under a
// range of capacity settings and every level setting. Each response beat
// is checked against its table row's value or the bench's shadow copy.
// ----------------------------------------------------------------------------
module tb_lru_tlb_lookup_insert import ltlb_pkg::*;;

   localparam int SLOTS           = DEF_MAX_ENTRIES;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int TAIL_CYCLES     = DEF_MAX_ENTRIES + 8;
   localparam int POOL_SIZE       = 20;
   localparam int PHASES          = 14;
   localparam int ITEMS_PER_PHASE = 128;
   localparam bit CHECKED         = 1'b1;
   localparam bit PREDICTED       = 1'b0;

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
      logic               evicted;
   } xlat_outcome_type;

   typedef enum logic {ROW_ACCESS, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          what;
      logic                  kind;
      ltlb_levels_type       key;
      logic [FRAME_W-1:0]    frame;
      logic                  checked;
      xlat_outcome_type      want;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_W-1:0]      csr_val;
   } plan_row_type;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 start             = 1'b0;
   logic                 busy;
   logic                 req_kind          = KIND_LOOKUP;
   logic [LVL_W-1:0]     req_level_index_0 = '0;
   logic [LVL_W-1:0]     req_level_index_1 = '0;
   logic [LVL_W-1:0]     req_level_index_2 = '0;
   logic [LVL_W-1:0]     req_level_index_3 = '0;
   logic [FRAME_W-1:0]   req_frame_number  = '0;
   logic                 rsp_valid;
   logic                 rsp_hit;
   logic [FRAME_W-1:0]   rsp_hit_frame;
   logic                 rsp_evicted;
   logic                 csr_wr_en         = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index         = CSR_CAPACITY;
   logic [CSR_W-1:0]     csr_wdata         = '0;

   // shadow copy of the buffer
   logic [CAP_W-1:0]   cap_reg = CAPACITY_RESET;
   logic [LVLS_W-1:0]  lvl_reg = LEVELS_RESET;
   ltlb_levels_type    slot_key   [SLOTS];
   logic [FRAME_W-1:0] slot_frame [SLOTS];
   bit                 slot_used  [SLOTS];
   int unsigned        slot_age   [SLOTS];
   int unsigned        fill_count = 0;

   xlat_outcome_type outcome_q [$];
   xlat_outcome_type head_want;
   int unsigned      mismatch_count = 0;
   int unsigned      rsp_beats      = 0;
   int unsigned      cycle_count    = 0;

   lru_tlb_lookup_insert dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on response beat %0d: %s got %0h want %0h",
               rsp_beats, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (outcome_q.size() == 0) begin
            report_mismatch("beat with nothing pending", 1, 0);
         end else begin
            head_want = outcome_q.pop_front();
            if (rsp_hit !== head_want.hit)
               report_mismatch("hit", rsp_hit, head_want.hit);
            if (rsp_hit_frame !== head_want.frame)
               report_mismatch("hit_frame", rsp_hit_frame, head_want.frame);
            if (rsp_evicted !== head_want.evicted)
               report_mismatch("evicted", rsp_evicted, head_want.evicted);
         end
         rsp_beats++;
      end
   end

   function automatic xlat_outcome_type shadow_access(input logic kind,
                                                      input ltlb_levels_type key,
                                                      input logic [FRAME_W-1:0] frame);
      xlat_outcome_type res;
      int               pick;
      int unsigned      best;
      int unsigned      depth;
      int unsigned      room;
      int unsigned      guard;
      bit               same;
      bit               placed;
      res = '0;
      if (kind == KIND_LOOKUP) begin
         depth = (lvl_reg == 0) ? 1 : lvl_reg;
         if (depth > NUM_LEVEL_PORTS) depth = NUM_LEVEL_PORTS;
         if (depth > DEF_MAX_LEVELS) depth = DEF_MAX_LEVELS;
         pick = -1;
         best = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
               same = 1'b1;
               for (int l = 0; l < depth; l++)
                  if (slot_key[i][l] != key[l]) same = 1'b0;
               // duplicates: the oldest matching copy wins
               if (same && (pick < 0 || slot_age[i] > best)) begin
                  pick = i;
                  best = slot_age[i];
               end
            end
         end
         if (pick >= 0) begin
            for (int i = 0; i < SLOTS; i++)
               if (slot_used[i] && slot_age[i] < best) slot_age[i]++;
            slot_age[pick] = 0;
            res.hit = 1'b1;
            res.frame = slot_frame[pick];
         end
      end else begin
         room = (cap_reg > SLOTS) ? SLOTS : cap_reg;
         if (room != 0) begin
            // shrunk capacity may need several evictions
            for (guard = 0; guard < SLOTS && fill_count >= room; guard++) begin
               pick = -1;
               best = 0;
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_used[i] && (pick < 0 || slot_age[i] >= best)) begin
                     pick = i;
                     best = slot_age[i];
                  end
               end
               if (pick >= 0) begin
                  slot_used[pick] = 1'b0;
                  slot_age[pick] = 0;
                  if (fill_count > 0) fill_count--;
               end
               res.evicted = 1'b1;
            end
            placed = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (!placed && !slot_used[i]) begin
                  for (int j = 0; j < SLOTS; j++)
                     if (slot_used[j]) slot_age[j]++;
                  slot_key[i] = key;
                  slot_frame[i] = frame;
                  slot_used[i] = 1'b1;
                  slot_age[i] = 0;
                  fill_count++;
                  placed = 1'b1;
               end
            end
         end
      end
      return res;
   endfunction

   function automatic logic [LVL_W-1:0] rand_level();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return LVL_W'($urandom);
      endcase
   endfunction

   function automatic plan_row_type op_row(input logic kind, input logic [LVL_W-1:0] l0,
                                           input logic [LVL_W-1:0] l1,
                                           input logic [LVL_W-1:0] l2,
                                           input logic [LVL_W-1:0] l3,
                                           input logic [FRAME_W-1:0] frame,
                                           input bit checked, input logic hit,
                                           input logic [FRAME_W-1:0] hit_frame,
                                           input logic evicted);
      plan_row_type row;
      row = '0;
      row.what = ROW_ACCESS;
      row.kind = kind;
      row.key = {l3, l2, l1, l0};
      row.frame = frame;
      row.checked = checked;
      row.want = '{hit: hit, frame: hit_frame, evicted: evicted};
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_W-1:0] value);
      plan_row_type row;
      row = '0;
      row.what = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = value;
      return row;
   endfunction

   // start is left high after an accepted beat; the next call either keeps
   // it high (no gap) or drops it, so it gets one update per edge
   task automatic issue_beat(input logic kind, input ltlb_levels_type key,
                             input logic [FRAME_W-1:0] frame, input int unsigned gap,
                             input bit checked, input xlat_outcome_type typed_want);
      xlat_outcome_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_kind          <= kind;
      req_level_index_0 <= key[0];
      req_level_index_1 <= key[1];
      req_level_index_2 <= key[2];
      req_level_index_3 <= key[3];
      req_frame_number  <= frame;
      do @(posedge clock); while (busy);
      predicted = shadow_access(kind, key, frame);
      outcome_q.push_back(checked ? typed_want : predicted);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (outcome_q.size() != 0 || busy) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_CAPACITY) cap_reg = value[CAP_W-1:0];
      else lvl_reg = value[LVLS_W-1:0];
   endtask

   initial begin
      plan_row_type       plan [$];
      ltlb_levels_type    pool [POOL_SIZE];
      ltlb_levels_type    key;
      logic [FRAME_W-1:0] frame;
      logic               kind;
      int unsigned        gap;
      bit                 no_gaps;
      logic [CSR_W-1:0]   cap_pick [10];

      for (int i = 0; i < SLOTS; i++) begin
         slot_key[i] = '0;
         slot_frame[i] = '0;
         slot_used[i] = 1'b0;
         slot_age[i] = 0;
      end
      cap_pick = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd0, 5'd3, 5'd8, 5'd15, 5'd17, 5'd5};

      plan = '{
         // empty buffer after reset
         op_row(KIND_LOOKUP, 16'h0, 16'h0, 16'h0, 16'h0, 20'h0,
                CHECKED, 1'b0, 20'h0, 1'b0),
         op_row(KIND_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF,
                CHECKED, 1'b0, 20'h0, 1'b0),
         op_row(KIND_INSERT, 16'h0, 16'h0, 16'h0, 16'h0, 20'h0,
                CHECKED, 1'b0, 20'h0, 1'b0),
         op_row(KIND_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF,
                CHECKED, 1'b0, 20'h0, 1'b0),
         // one level compared: upper levels do not matter
         op_row(KIND_LOOKUP, 16'hFFFF, 16'h0, 16'h0, 16'h0, 20'h0,
                CHECKED, 1'b1, 20'hFFFFF, 1'b0),
         op_row(KIND_LOOKUP, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF,
                CHECKED, 1'b1, 20'h0, 1'b0),
         op_row(KIND_INSERT, 16'h1234, 16'h1, 16'h2, 16'h3, 20'hABCDE,
                CHECKED, 1'b0, 20'h0, 1'b0),
         op_row(KIND_INSERT, 16'h1234, 16'h4, 16'h5, 16'h6, 20'h12345,
                CHECKED, 1'b0, 20'h0, 1'b0),
         // duplicate keys: oldest copy answers, then moves to the front
         op_row(KIND_LOOKUP, 16'h1234, 16'h0, 16'h0, 16'h0, 20'h0,
                PREDICTED, 1'b0, 20'h0, 1'b0),
         op_row(KIND_LOOKUP, 16'h1234, 16'h0, 16'h0, 16'h0, 20'h0,
                PREDICTED, 1'b0, 20'h0, 1'b0),
         csr_row(CSR_LEVELS, 5'd4),
         op_row(KIND_LOOKUP, 16'h1234, 16'h1, 16'h2, 16'h3, 20'h0,
                PREDICTED, 1'b0, 20'h0, 1'b0),
         op_row(KIND_LOOKUP, 16'h1234, 16'h1, 16'h2, 16'h7, 20'h0,
                PREDICTED, 1'b0, 20'h0, 1'b0),
         csr_row(CSR_LEVELS, 5'd2),
         op_row(KIND_LOOKUP, 16'h1234, 16'h4, 16'h9, 16'h9, 20'h0,
                PREDICTED, 1'b0, 20'h0, 1'b0),
         // capacity below the fill level
         csr_row(CSR_CAPACITY, 5'd2),
         op_row(KIND_INSERT, 16'h5, 16'h5, 16'h5, 16'h5, 20'h55555,
                CHECKED, 1'b0, 20'h0, 1'b1),
         op_row(KIND_INSERT, 16'h6, 16'h6, 16'h6, 16'h6, 20'h66666,
                PREDICTED, 1'b0, 20'h0, 1'b0),
         // capacity zero drops inserts, keeps entries
         csr_row(CSR_CAPACITY, 5'd0),
         op_row(KIND_INSERT, 16'h7, 16'h7, 16'h7, 16'h7, 20'h77777,
                CHECKED, 1'b0, 20'h0, 1'b0),
         op_row(KIND_LOOKUP, 16'h6, 16'h6, 16'h6, 16'h6, 20'h0,
                PREDICTED, 1'b0, 20'h0, 1'b0),
         // saturated capacity, zero levels
         csr_row(CSR_CAPACITY, 5'd31),
         csr_row(CSR_LEVELS, 5'd0),
         op_row(KIND_INSERT, 16'h8, 16'h8, 16'h8, 16'h8, 20'h88888,
                PREDICTED, 1'b0, 20'h0, 1'b0),
         op_row(KIND_LOOKUP, 16'h5, 16'hAAAA, 16'h0, 16'h0, 20'h0,
                PREDICTED, 1'b0, 20'h0, 1'b0),
         csr_row(CSR_LEVELS, 5'd7),
         op_row(KIND_LOOKUP, 16'h8, 16'h8, 16'h8, 16'h8, 20'h0,
                PREDICTED, 1'b0, 20'h0, 1'b0),
         csr_row(CSR_CAPACITY, 5'd1),
         op_row(KIND_INSERT, 16'h9, 16'h9, 16'h9, 16'h9, 20'h99999,
                CHECKED, 1'b0, 20'h0, 1'b1),
         csr_row(CSR_CAPACITY, 5'd16),
         csr_row(CSR_LEVELS, 5'd1)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].what == ROW_CSR)
            write_reg(plan[r].csr_idx, plan[r].csr_val);
         else
            issue_beat(plan[r].kind, plan[r].key, plan[r].frame, $urandom_range(0, 12),
                       plan[r].checked, plan[r].want);
      end

      // random phases; each starts from an idle buffer with a new setting
      for (int ph = 0; ph < PHASES; ph++) begin
         write_reg(CSR_CAPACITY, cap_pick[ph % 10]);
         write_reg(CSR_LEVELS, CSR_W'((ph * 3) % 8));
         no_gaps = (ph % 4 == 2);
         for (int p = 0; p < POOL_SIZE; p++)
            if (ph == 0 || $urandom_range(0, 3) == 0)
               for (int l = 0; l < NUM_LEVEL_PORTS; l++) pool[p][l] = rand_level();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            kind = ($urandom_range(0, 99) < 40) ? KIND_INSERT : KIND_LOOKUP;
            if ($urandom_range(0, 9) == 0) begin
               for (int l = 0; l < NUM_LEVEL_PORTS; l++) key[l] = rand_level();
            end else begin
               key = pool[$urandom_range(0, POOL_SIZE - 1)];
               // near-miss keys: only the compared levels decide
               if ($urandom_range(0, 3) == 0) key[$urandom_range(0, 3)] = rand_level();
            end
            case ($urandom_range(0, 19))
               0: frame = '0;
               1: frame = '1;
               default: frame = FRAME_W'($urandom);
            endcase
            gap = no_gaps ? 0 : $urandom_range(0, 12);
            issue_beat(kind, key, frame, gap, PREDICTED, '0);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (outcome_q.size() != 0)
         report_mismatch("beats never seen", outcome_q.size(), 0);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
